@@ hdl/fbc_pkg.sv @@
// Shared types and constants for the frustum box cull test.
package fbc_pkg;

	localparam int NUM_PLANES  = 6;
	localparam int NUM_AXES    = 3;
	localparam int NORM_W      = 16;
	localparam int NORM_FRAC   = 14;
	localparam int DIST_W      = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;
	localparam int CELL_STAGES = 2;
	localparam int PIPE_LAT    = NUM_PLANES * CELL_STAGES;

	// Register indexes, address is index times eight
	localparam logic [2:0] REG_PLANE_LEFT   = 3'd0;
	localparam logic [2:0] REG_PLANE_RIGHT  = 3'd1;
	localparam logic [2:0] REG_PLANE_BOTTOM = 3'd2;
	localparam logic [2:0] REG_PLANE_TOP    = 3'd3;
	localparam logic [2:0] REG_PLANE_NEAR   = 3'd4;
	localparam logic [2:0] REG_PLANE_FAR    = 3'd5;

	// One plane register: normal in Q1.14, distance in Q15.0
	typedef struct packed {
		logic signed [DIST_W-1:0] distance;
		logic signed [NORM_W-1:0] nz;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nx;
	} plane_t;

endpackage

@@ hdl/fbc_regs.sv @@
// APB register file holding the six plane registers.
module fbc_regs
	import fbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output plane_t                planes [NUM_PLANES]
);

	plane_t      plane_q [NUM_PLANES];
	logic [2:0]  reg_idx;
	logic        wr_en;

	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Write the addressed plane on the access cycle, drop writes past the last plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PLANE_LEFT:   plane_q[0] <= plane_t'(pwdata);
				REG_PLANE_RIGHT:  plane_q[1] <= plane_t'(pwdata);
				REG_PLANE_BOTTOM: plane_q[2] <= plane_t'(pwdata);
				REG_PLANE_TOP:    plane_q[3] <= plane_t'(pwdata);
				REG_PLANE_NEAR:   plane_q[4] <= plane_t'(pwdata);
				REG_PLANE_FAR:    plane_q[5] <= plane_t'(pwdata);
				default: ;
			endcase
		end
	end

	// Read back the addressed plane
	always_comb begin
		unique case (reg_idx)
			REG_PLANE_LEFT:   prdata = plane_q[0];
			REG_PLANE_RIGHT:  prdata = plane_q[1];
			REG_PLANE_BOTTOM: prdata = plane_q[2];
			REG_PLANE_TOP:    prdata = plane_q[3];
			REG_PLANE_NEAR:   prdata = plane_q[4];
			REG_PLANE_FAR:    prdata = plane_q[5];
			default:          prdata = '0;
		endcase
	end

	assign planes = plane_q;

endmodule

@@ hdl/fbc_cell.sv @@
// One plane cell: p-vertex pick, exact dot product, sign test, box handed on.
module fbc_cell
	import fbc_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  plane_t                               plane,
	input  logic                                 in_valid,
	input  logic                                 in_vis,
	input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] in_lo,
	input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] in_hi,
	output logic                                 out_valid,
	output logic                                 out_vis,
	output logic [NUM_AXES-1:0][COORD_WIDTH-1:0] out_lo,
	output logic [NUM_AXES-1:0][COORD_WIDTH-1:0] out_hi
);

	localparam int PROD_W  = NORM_W + COORD_WIDTH;
	localparam int DTERM_W = DIST_W + NORM_FRAC;
	localparam int SUM_W   = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;

	logic signed [NORM_W-1:0]      norm [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] corner [NUM_AXES];
	logic signed [PROD_W-1:0]      prod [NUM_AXES];
	logic signed [DTERM_W-1:0]     dterm;
	logic signed [SUM_W-1:0]       sum;

	logic                                 valid_s1, vis_s1;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo_s1, hi_s1;
	logic signed [PROD_W-1:0]             prod_s1 [NUM_AXES];
	logic signed [DTERM_W-1:0]            dterm_s1;

	logic                                 valid_s2, vis_s2;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo_s2, hi_s2;

	assign norm[0] = plane.nx;
	assign norm[1] = plane.ny;
	assign norm[2] = plane.nz;

	// Pick the corner farthest along the normal per axis and multiply
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			corner[a] = norm[a][NORM_W-1] ? $signed(in_lo[a]) : $signed(in_hi[a]);
			prod[a]   = norm[a] * corner[a];
		end
	end

	// Distance scaled to the product's 14 fraction bits
	assign dterm = {plane.distance, {NORM_FRAC{1'b0}}};

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		vis_s1   <= in_vis;
		lo_s1    <= in_lo;
		hi_s1    <= in_hi;
		dterm_s1 <= dterm;
		for (int a = 0; a < NUM_AXES; a++) begin
			prod_s1[a] <= prod[a];
		end
	end

	// Sum exactly, reject on a negative result
	assign sum = SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]) + SUM_W'(prod_s1[2])
		+ SUM_W'(dterm_s1);

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		vis_s2 <= vis_s1 && !sum[SUM_W-1];
		lo_s2  <= lo_s1;
		hi_s2  <= hi_s1;
	end

	assign out_valid = valid_s2;
	assign out_vis   = vis_s2;
	assign out_lo    = lo_s2;
	assign out_hi    = hi_s2;

endmodule

@@ hdl/frustum_box_cull_test.sv @@
// Top level of the frustum box cull test: register file and chain of plane cells.
//
// One box is taken on every cycle that start is high; busy stays low. The box walks a
// chain of six plane cells, one per frustum plane, each two stages deep (a multiply
// stage, then a sum and sign stage), so the visible result appears with done once the
// box has passed every stage of the chain and holds for one cycle only. The receiver
// cannot stall the chain. Plane registers sit on the APB port at byte address 8*i and
// should be written only while no box is in flight.
module frustum_box_cull_test
	import fbc_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] box_min_x,
	input  logic signed [COORD_WIDTH-1:0] box_min_y,
	input  logic signed [COORD_WIDTH-1:0] box_min_z,
	input  logic signed [COORD_WIDTH-1:0] box_max_x,
	input  logic signed [COORD_WIDTH-1:0] box_max_y,
	input  logic signed [COORD_WIDTH-1:0] box_max_z,
	output logic                          done,
	output logic                          visible,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [CFG_ADDR_W-1:0]         paddr,
	input  logic [CFG_DATA_W-1:0]         pwdata,
	output logic [CFG_DATA_W-1:0]         prdata,
	output logic                          pready
);

	plane_t planes [NUM_PLANES];

	logic                                 valid_c [NUM_PLANES+1];
	logic                                 vis_c   [NUM_PLANES+1];
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo_c    [NUM_PLANES+1];
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] hi_c    [NUM_PLANES+1];

	assign busy = 1'b0;

	fbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.planes  (planes)
	);

	// Feed the head of the chain
	assign valid_c[0] = start && !busy;
	assign vis_c[0]   = 1'b1;
	assign lo_c[0]    = {box_min_z, box_min_y, box_min_x};
	assign hi_c[0]    = {box_max_z, box_max_y, box_max_x};

	// One cell per plane
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
		fbc_cell #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.plane     (planes[p]),
			.in_valid  (valid_c[p]),
			.in_vis    (vis_c[p]),
			.in_lo     (lo_c[p]),
			.in_hi     (hi_c[p]),
			.out_valid (valid_c[p+1]),
			.out_vis   (vis_c[p+1]),
			.out_lo    (lo_c[p+1]),
			.out_hi    (hi_c[p+1])
		);
	end

	assign done    = valid_c[NUM_PLANES];
	assign visible = vis_c[NUM_PLANES];

endmodule

@@ hdl/fbc_checker.sv @@
// Port-level checks for the frustum box cull test, bound to the top level.
module fbc_checker
	import fbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic                  done,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic [CFG_DATA_W-1:0] prdata,
	input  logic                  pready
);

	// Every box transfer yields a result after the chain latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LAT done)
		else $error("box transfer without a result");

	// No result without a box transfer at the chain latency before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without a box transfer");

	// A write to the left plane reads back on the next access
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr == '0)
		##1 (psel && !pwrite && paddr == '0) |-> prdata == $past(pwdata))
		else $error("plane register readback mismatch");

	// Port never stalls a transfer
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready && !busy)
		else $error("port stalled");

endmodule

bind frustum_box_cull_test fbc_checker u_fbc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.pready  (pready)
);

@@ test/tb.sv @@
// Testbench for frustum_box_cull_test: box transfers checked against a plane-test predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fbc_pkg::*;

	localparam int CW      = 16;
	localparam int CMAX    = 32767;
	localparam int CMIN    = -32768;
	localparam int N_PHASE = 9;
	localparam int PER_PHASE = 100;

	typedef struct {
		logic signed [CW-1:0] lo [NUM_AXES];
		logic signed [CW-1:0] hi [NUM_AXES];
	} box_t;

	typedef enum int {
		PLANES_CUBE,
		PLANES_RANDOM,
		PLANES_NEG_EXT,
		PLANES_POS_EXT,
		PLANES_MIXED
	} plane_set_e;

	// Holds a copy of the plane registers and the visibility flags still owed by the chain
	class cull_scoreboard;
		plane_t planes [NUM_PLANES];
		bit     owed_visible [$];
		int     errors;

		function new();
			foreach (planes[p]) planes[p] = '0;
			errors = 0;
		endfunction

		// Registers past the last plane ignore writes
		function void set_plane(int idx, logic [CFG_DATA_W-1:0] value);
			if (idx < NUM_PLANES) planes[idx] = value;
		endfunction

		// Farthest corner along each normal, exact dot product plus scaled distance
		function bit box_visible(box_t b);
			logic signed [NORM_W-1:0] nrm [NUM_AXES];
			longint sum, n, c;
			bit vis;
			vis = 1'b1;
			for (int p = 0; p < NUM_PLANES; p++) begin
				nrm[0] = planes[p].nx;
				nrm[1] = planes[p].ny;
				nrm[2] = planes[p].nz;
				sum = longint'(planes[p].distance) * (longint'(1) << NORM_FRAC);
				for (int a = 0; a < NUM_AXES; a++) begin
					n = nrm[a];
					c = (n >= 0) ? longint'(b.hi[a]) : longint'(b.lo[a]);
					sum += n * c;
				end
				if (sum < 0) vis = 1'b0;
			end
			return vis;
		endfunction

		function void note_box(box_t b);
			owed_visible.push_back(box_visible(b));
		endfunction

		function void check_result(logic vis);
			bit exp_vis;
			if (owed_visible.size() == 0) begin
				$display("%0t ERROR unexpected result: expected none, actual visible=%0b",
					$time, vis);
				errors++;
			end else begin
				exp_vis = owed_visible.pop_front();
				if (vis !== exp_vis) begin
					$display("%0t ERROR visible mismatch: expected %0b, actual %0b",
						$time, exp_vis, vis);
					errors++;
				end
			end
		endfunction

		function int pending();
			return owed_visible.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic signed [CW-1:0]  box_min_x, box_min_y, box_min_z;
	logic signed [CW-1:0]  box_max_x, box_max_y, box_max_z;
	logic                  done;
	logic                  visible;
	logic                  psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	cull_scoreboard sb;
	int             reach;

	frustum_box_cull_test #(.COORD_WIDTH(CW)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z),
		.done      (done),
		.visible   (visible),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sample box transfers and result strobes at the edge that completes them
	always @(posedge clk) begin : monitor
		box_t seen;
		if (arst_n) begin
			if (start && !busy) begin
				seen.lo[0] = box_min_x;
				seen.lo[1] = box_min_y;
				seen.lo[2] = box_min_z;
				seen.hi[0] = box_max_x;
				seen.hi[1] = box_max_y;
				seen.hi[2] = box_max_z;
				sb.note_box(seen);
			end
			if (done) sb.check_result(visible);
		end
	end

	function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
		box_t b;
		b.lo[0] = CW'(lx);
		b.lo[1] = CW'(ly);
		b.lo[2] = CW'(lz);
		b.hi[0] = CW'(hx);
		b.hi[1] = CW'(hy);
		b.hi[2] = CW'(hz);
		return b;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] mk_plane(int nx, int ny, int nz, int distance);
		plane_t p;
		p.nx       = NORM_W'(nx);
		p.ny       = NORM_W'(ny);
		p.nz       = NORM_W'(nz);
		p.distance = DIST_W'(distance);
		return p;
	endfunction

	function automatic int clamp_coord(int v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	// Idle cycles before the next transfer, each cycle idle with the given odds
	function automatic int idle_gap(int pct);
		int gap;
		gap = 0;
		while (gap < 100 && $urandom_range(99) < pct) gap++;
		return gap;
	endfunction

	// Half well-formed boxes near the frustum, the rest points, extreme corners and noise
	function automatic box_t rand_box();
		box_t b;
		int   kind, lo_v, hi_v, ext;
		int   corner [4];
		corner = '{CMIN, CMAX, 0, -1};
		kind = $urandom_range(99);
		for (int a = 0; a < NUM_AXES; a++) begin
			if (kind < 50) begin
				lo_v = clamp_coord($urandom_range(2 * reach) - reach);
				ext  = ($urandom_range(3) == 0) ? $urandom_range(CMAX) : $urandom_range(reach);
				hi_v = clamp_coord(lo_v + ext);
			end else if (kind < 65) begin
				lo_v = clamp_coord($urandom_range(2 * reach) - reach);
				hi_v = lo_v;
			end else if (kind < 75) begin
				lo_v = corner[$urandom_range(3)];
				hi_v = corner[$urandom_range(3)];
			end else begin
				lo_v = $signed(16'($urandom));
				hi_v = $signed(16'($urandom));
			end
			b.lo[a] = CW'(lo_v);
			b.hi[a] = CW'(hi_v);
		end
		return b;
	endfunction

	// Present one box after an idle gap and hold it until the transfer
	task automatic send_box(box_t b, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		box_min_x <= b.lo[0];
		box_min_y <= b.lo[1];
		box_min_z <= b.lo[2];
		box_max_x <= b.hi[0];
		box_max_y <= b.hi[1];
		box_max_z <= b.hi[2];
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start and wait for the chain to empty
	task automatic settle_chain();
		start <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// Setup cycle, access cycle, then idle before the next transfer
	task automatic write_plane(int idx, logic [CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(idx * 8);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_plane(idx, value);
		@(posedge clk);
	endtask

	task automatic load_planes(plane_set_e kind);
		int d;
		case (kind)
			PLANES_CUBE: begin
				d = $urandom_range(16'h2000, 16'h0040);
				reach = clamp_coord(2 * d);
				write_plane(REG_PLANE_LEFT,   mk_plane(16'sh4000, 0, 0, d));
				write_plane(REG_PLANE_RIGHT,  mk_plane(-16'sh4000, 0, 0, d));
				write_plane(REG_PLANE_BOTTOM, mk_plane(0, 16'sh4000, 0, d));
				write_plane(REG_PLANE_TOP,    mk_plane(0, -16'sh4000, 0, d));
				write_plane(REG_PLANE_NEAR,   mk_plane(0, 0, 16'sh4000, d));
				write_plane(REG_PLANE_FAR,    mk_plane(0, 0, -16'sh4000, d));
				// Unmapped slots past the far plane take the write and change nothing
				write_plane(NUM_PLANES,     {$urandom, $urandom});
				write_plane(NUM_PLANES + 1, {$urandom, $urandom});
			end
			PLANES_RANDOM: begin
				reach = CMAX;
				for (int p = 0; p < NUM_PLANES; p++) write_plane(p, {$urandom, $urandom});
			end
			PLANES_NEG_EXT: begin
				reach = CMAX;
				for (int p = 0; p < NUM_PLANES; p++)
					write_plane(p, mk_plane(CMIN, CMIN, CMIN, CMIN));
			end
			PLANES_POS_EXT: begin
				reach = CMAX;
				for (int p = 0; p < NUM_PLANES; p++)
					write_plane(p, mk_plane(CMAX, CMAX, CMAX, CMAX));
			end
			default: begin
				reach = CMAX;
				for (int p = 0; p < NUM_PLANES; p++)
					write_plane(p, (p % 2 == 0) ?
						mk_plane($urandom, $urandom, $urandom, CMAX) :
						mk_plane(CMIN, CMAX, CMIN, $urandom));
			end
		endcase
	endtask

	task automatic run_boxes(int count, int pct);
		for (int i = 0; i < count; i++) send_box(rand_box(), idle_gap(pct));
	endtask

	// Boundary, outside-each-plane, extreme and reversed boxes against the cube planes
	task automatic run_directed();
		box_t list [$];
		int   d;
		d = 16'h0400;
		reach = 2 * d;
		write_plane(REG_PLANE_LEFT,   mk_plane(16'sh4000, 0, 0, d));
		write_plane(REG_PLANE_RIGHT,  mk_plane(-16'sh4000, 0, 0, d));
		write_plane(REG_PLANE_BOTTOM, mk_plane(0, 16'sh4000, 0, d));
		write_plane(REG_PLANE_TOP,    mk_plane(0, -16'sh4000, 0, d));
		write_plane(REG_PLANE_NEAR,   mk_plane(0, 0, 16'sh4000, d));
		write_plane(REG_PLANE_FAR,    mk_plane(0, 0, -16'sh4000, d));
		list.push_back(mk_box(-16, -16, -16, 16, 16, 16));
		list.push_back(mk_box(0, 0, 0, 0, 0, 0));
		list.push_back(mk_box(d, 0, 0, d, 0, 0));
		list.push_back(mk_box(d + 1, 0, 0, d + 1, 0, 0));
		list.push_back(mk_box(-d - 1, 0, 0, -d - 1, 0, 0));
		list.push_back(mk_box(0, d + 1, 0, 0, d + 1, 0));
		list.push_back(mk_box(0, -d - 1, 0, 0, -d - 1, 0));
		list.push_back(mk_box(0, 0, d + 1, 0, 0, d + 1));
		list.push_back(mk_box(0, 0, -d - 1, 0, 0, -d - 1));
		list.push_back(mk_box(-d - 50, -5, -5, -d + 50, 5, 5));
		list.push_back(mk_box(d - 50, -5, -5, d + 50, 5, 5));
		list.push_back(mk_box(2 * d, 2 * d, 2 * d, 3 * d, 3 * d, 3 * d));
		list.push_back(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		list.push_back(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		list.push_back(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
		list.push_back(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
		list.push_back(mk_box(100, 0, 0, -100, 0, 0));
		list.push_back(mk_box(d + 10, 0, 0, -d - 10, 0, 0));
		list.push_back(mk_box(-1, -1, -1, -1, -1, -1));
		list.push_back(mk_box(CMIN, 0, CMAX, CMAX, 0, CMIN));
		foreach (list[i]) send_box(list[i], (i % 4 == 3) ? 1 : 0);
	endtask

	initial begin
		int idle_pct [3];
		idle_pct = '{0, 86, 28};
		sb = new();
		reach     = CMAX;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		box_min_x <= '0;
		box_min_y <= '0;
		box_min_z <= '0;
		box_max_x <= '0;
		box_max_y <= '0;
		box_max_z <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Planes still at reset: every box passes
		run_boxes(40, 0);
		settle_chain();

		run_directed();
		settle_chain();

		// Walk plane settings and idle patterns together
		for (int k = 0; k < N_PHASE; k++) begin
			load_planes(plane_set_e'(k % 5));
			run_boxes(PER_PHASE, idle_pct[k % 3]);
			settle_chain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("frustum_box_cull_test verification clean");
		end else begin
			if (sb.pending() != 0)
				$display("%0t ERROR results missing: expected %0d more, actual 0",
					$time, sb.pending());
			$display("frustum_box_cull_test verification failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("frustum_box_cull_test verification failed");
		$finish;
	end

endmodule
